// ===== hw/rtl/baro_conversion_scheduler_compensator_macros.svh =====
// Assertion macros for the barometric conversion scheduler.
// Every macro samples on aclk and is disabled while aresetn is low.
`ifndef BARO_CONVERSION_SCHEDULER_COMPENSATOR_MACROS_SVH
`define BARO_CONVERSION_SCHEDULER_COMPENSATOR_MACROS_SVH

// Same-cycle implication.
`define BCSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BCSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/bcsc_pkg.sv =====
// Shared constants for the barometric conversion scheduler and compensator.
// No dependencies; used by baro_conversion_scheduler_compensator.
`timescale 1ns / 1ps
`default_nettype none

package bcsc_pkg;

    localparam int TIME_W   = 32;
    localparam int ADC_W    = 24;
    localparam int COEFF_W  = 16;
    localparam int OVS_W    = 4;
    localparam int CMD_W    = 8;
    localparam int FETCH_W  = 2;
    localparam int VALUE_W  = 64;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W = 64;  // now_us + adc_value + adc_ok = 57, padded
    localparam int M_TDATA_W = 80;  // start_command + fetched + value = 74, padded

    // conversion start bytes
    localparam logic [CMD_W-1:0] CMD_D1 = 8'h40;
    localparam logic [CMD_W-1:0] CMD_D2 = 8'h50;

    // fetched codes
    localparam logic [FETCH_W-1:0] FETCH_NONE  = 2'd0;
    localparam logic [FETCH_W-1:0] FETCH_PRESS = 2'd1;
    localparam logic [FETCH_W-1:0] FETCH_TEMP  = 2'd2;

    // query kinds
    localparam logic KIND_PRESS = 1'b0;
    localparam logic KIND_TEMP  = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SENS     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFF      = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TCS      = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TCO      = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TREF     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TEMPSENS = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OVS      = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_WAIT     = 4'd7;

    localparam logic [TIME_W-1:0] CONV_WAIT_RESET = 32'd10000;
    localparam logic [31:0]       RAW_FAIL        = 32'hFFFF_FFFF;

    // compensation constants
    localparam logic signed [VALUE_W-1:0] TEMP_BASE = 64'sd2000;
    localparam int SH_TEMP = 23;
    localparam int SH_OFF  = 7;
    localparam int SH_SENS = 8;
    localparam int SH_PROD = 21;
    localparam int SH_PRES = 15;

endpackage

`default_nettype wire

// ===== hw/rtl/baro_conversion_scheduler_compensator.sv =====
// Barometric conversion scheduler with first-order compensation (top level).
// Depends on bcsc_pkg and baro_conversion_scheduler_compensator_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "baro_conversion_scheduler_compensator_macros.svh"

// Channel   | Direction | Handshake          | Content
// ----------+-----------+--------------------+----------------------------------------
// s_        | in        | s_tvalid/s_tready  | query: kind, time, ADC word, read status
// m_        | out       | m_tvalid/m_tready  | start byte, fetch code, valid flag, value
// cfg_      | in        | cfg_valid/cfg_ready| register index and write data
//
// Steps: a temperature query goes through TSCH, DT, MUL_TS, TFIN and OUT to the
// result register, a pressure query through PSCH, TSCH, DT, MUL_TCO, MUL_TCS, SENS,
// PLO, PHI, PSUM, PFIN and OUT (it skips ahead to OUT when the result turns out invalid
// early); one 33x33 multiplier serves the dT products and both raw-times-SENS halves.
// s_tready is high only while the sequencer is idle; a finished result waits in
// the output register, so a new query can transfer while m_ stalls.
// Reset (aresetn low, synchronous) clears schedule state, caches and registers.
// cfg_ready is always high; write only while no query is in flight.

module baro_conversion_scheduler_compensator (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // query channel
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [bcsc_pkg::S_TDATA_W-1:0]  s_tdata,  // now_us[31:0], adc_value[55:32],
                                                           // adc_ok[56], zeros above
    input  wire logic                            s_tuser,  // kind[0]
    // result channel
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [bcsc_pkg::M_TDATA_W-1:0]       m_tdata,  // start_command[7:0], fetched[9:8],
                                                           // value[73:10], zeros above
    output logic                                 m_tuser,  // value_valid[0]
    // configuration write channel
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [bcsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bcsc_pkg::CFG_DATA_W-1:0] cfg_data
);

    // sequencer states
    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_PSCH    = 4'd1;   // pressure schedule
    localparam logic [3:0] ST_TSCH    = 4'd2;   // temperature schedule
    localparam logic [3:0] ST_DT      = 4'd3;   // form dT and validity
    localparam logic [3:0] ST_MUL_TS  = 4'd4;   // dT * C6
    localparam logic [3:0] ST_TFIN    = 4'd5;   // TEMP
    localparam logic [3:0] ST_MUL_TCO = 4'd6;   // dT * C4
    localparam logic [3:0] ST_MUL_TCS = 4'd7;   // dT * C3, OFF
    localparam logic [3:0] ST_SENS    = 4'd8;   // SENS
    localparam logic [3:0] ST_PLO     = 4'd9;   // raw * SENS low half
    localparam logic [3:0] ST_PHI     = 4'd10;  // raw * SENS high half
    localparam logic [3:0] ST_PSUM    = 4'd11;  // combine halves
    localparam logic [3:0] ST_PFIN    = 4'd12;  // P
    localparam logic [3:0] ST_OUT     = 4'd13;  // hand to output register

    localparam int TW = bcsc_pkg::TIME_W;
    localparam int VW = bcsc_pkg::VALUE_W;
    localparam int CW = bcsc_pkg::COEFF_W;

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    logic [3:0]          state_reg, state_next;

    // configuration
    logic [CW-1:0]       c_sens_reg, c_sens_next;
    logic [CW-1:0]       c_off_reg, c_off_next;
    logic [CW-1:0]       c_tcs_reg, c_tcs_next;
    logic [CW-1:0]       c_tco_reg, c_tco_next;
    logic [CW-1:0]       c_tref_reg, c_tref_next;
    logic [CW-1:0]       c_tsens_reg, c_tsens_next;
    logic [bcsc_pkg::OVS_W-1:0] ovs_reg, ovs_next;
    logic [TW-1:0]       wait_reg, wait_next;

    // schedule state
    logic [TW-1:0]       press_start_reg, press_start_next;
    logic [TW-1:0]       temp_start_reg, temp_start_next;
    logic [31:0]         press_cache_reg, press_cache_next;
    logic [31:0]         temp_cache_reg, temp_cache_next;

    // captured query
    logic                kind_reg, kind_next;
    logic [TW-1:0]       now_reg, now_next;
    logic [bcsc_pkg::ADC_W-1:0] adc_reg, adc_next;
    logic                ok_reg, ok_next;

    // datapath
    logic [31:0]         dt_reg, dt_next;
    logic signed [VW-1:0] prod_reg, prod_next;
    logic signed [VW-1:0] off_reg, off_next;
    logic signed [VW-1:0] sens_reg, sens_next;
    logic signed [VW-1:0] acc_reg, acc_next;

    // working result
    logic [bcsc_pkg::CMD_W-1:0]   cmd_reg, cmd_next;
    logic [bcsc_pkg::FETCH_W-1:0] fetched_reg, fetched_next;
    logic                         valid_reg, valid_next;
    logic signed [VW-1:0]         value_reg, value_next;

    // output register
    logic                         out_valid_reg, out_valid_next;
    logic [bcsc_pkg::CMD_W-1:0]   out_cmd_reg, out_cmd_next;
    logic [bcsc_pkg::FETCH_W-1:0] out_fetched_reg, out_fetched_next;
    logic                         out_vv_reg, out_vv_next;
    logic signed [VW-1:0]         out_value_reg, out_value_next;

    // ------------------------------------------------------------------
    // shared multiplier: one signed 33x33 product per cycle
    // ------------------------------------------------------------------
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MUL_TS: begin
                mul_a = $signed({dt_reg[31], dt_reg});
                mul_b = $signed({17'd0, c_tsens_reg});
            end
            ST_MUL_TCO: begin
                mul_a = $signed({dt_reg[31], dt_reg});
                mul_b = $signed({17'd0, c_tco_reg});
            end
            ST_MUL_TCS: begin
                mul_a = $signed({dt_reg[31], dt_reg});
                mul_b = $signed({17'd0, c_tcs_reg});
            end
            ST_PLO: begin
                mul_a = $signed({1'b0, press_cache_reg});
                mul_b = $signed({1'b0, sens_reg[31:0]});
            end
            ST_PHI: begin
                // only the low 32 bits of this partial product survive the wrap
                mul_a = $signed({1'b0, press_cache_reg});
                mul_b = $signed({1'b0, sens_reg[63:32]});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // arithmetic shifts of registered products
    logic signed [VW-1:0] sh_temp, sh_off, sh_sens, sh_acc, p_diff, p_val;

    assign sh_temp = prod_reg >>> bcsc_pkg::SH_TEMP;
    assign sh_off  = prod_reg >>> bcsc_pkg::SH_OFF;
    assign sh_sens = prod_reg >>> bcsc_pkg::SH_SENS;
    assign sh_acc  = acc_reg >>> bcsc_pkg::SH_PROD;
    assign p_diff  = sh_acc - off_reg;
    assign p_val   = p_diff >>> bcsc_pkg::SH_PRES;

    // elapsed-time tests, wrapping 32-bit
    logic [TW-1:0] press_elapsed, temp_elapsed;
    logic          press_due, temp_due;
    logic [31:0]   fetch_word;
    logic [31:0]   d32;

    assign press_elapsed = now_reg - press_start_reg;
    assign temp_elapsed  = now_reg - temp_start_reg;
    assign press_due  = (press_start_reg != '0) && (press_elapsed >= wait_reg);
    assign temp_due   = (temp_start_reg != '0) && (temp_elapsed >= wait_reg);
    assign fetch_word = ok_reg ? {8'd0, adc_reg} : bcsc_pkg::RAW_FAIL;
    assign d32        = temp_cache_reg - {8'd0, c_tref_reg, 8'd0};

    logic s_xfer, m_free;
    assign s_xfer = s_tvalid && s_tready;
    assign m_free = !out_valid_reg || m_tready;

    // ------------------------------------------------------------------
    // next-state logic
    // ------------------------------------------------------------------
    always_comb begin
        state_next       = state_reg;
        c_sens_next      = c_sens_reg;
        c_off_next       = c_off_reg;
        c_tcs_next       = c_tcs_reg;
        c_tco_next       = c_tco_reg;
        c_tref_next      = c_tref_reg;
        c_tsens_next     = c_tsens_reg;
        ovs_next         = ovs_reg;
        wait_next        = wait_reg;
        press_start_next = press_start_reg;
        temp_start_next  = temp_start_reg;
        press_cache_next = press_cache_reg;
        temp_cache_next  = temp_cache_reg;
        kind_next        = kind_reg;
        now_next         = now_reg;
        adc_next         = adc_reg;
        ok_next          = ok_reg;
        dt_next          = dt_reg;
        prod_next        = prod_reg;
        off_next         = off_reg;
        sens_next        = sens_reg;
        acc_next         = acc_reg;
        cmd_next         = cmd_reg;
        fetched_next     = fetched_reg;
        valid_next       = valid_reg;
        value_next       = value_reg;
        out_cmd_next     = out_cmd_reg;
        out_fetched_next = out_fetched_reg;
        out_vv_next      = out_vv_reg;
        out_value_next   = out_value_reg;
        out_valid_next   = out_valid_reg && !m_tready;

        // configuration writes; unknown indexes drop
        if (cfg_valid) begin
            case (cfg_index)
                bcsc_pkg::REG_SENS:     c_sens_next  = cfg_data[CW-1:0];
                bcsc_pkg::REG_OFF:      c_off_next   = cfg_data[CW-1:0];
                bcsc_pkg::REG_TCS:      c_tcs_next   = cfg_data[CW-1:0];
                bcsc_pkg::REG_TCO:      c_tco_next   = cfg_data[CW-1:0];
                bcsc_pkg::REG_TREF:     c_tref_next  = cfg_data[CW-1:0];
                bcsc_pkg::REG_TEMPSENS: c_tsens_next = cfg_data[CW-1:0];
                bcsc_pkg::REG_OVS:      ovs_next     = cfg_data[bcsc_pkg::OVS_W-1:0];
                bcsc_pkg::REG_WAIT:     wait_next    = cfg_data[TW-1:0];
                default: ;
            endcase
        end

        // the multiplier result lands in prod_reg in every multiply state
        if (state_reg inside {ST_MUL_TS, ST_MUL_TCO, ST_MUL_TCS, ST_PLO, ST_PHI}) begin
            prod_next = mul_p[VW-1:0];
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    kind_next    = s_tuser;
                    now_next     = s_tdata[31:0];
                    adc_next     = s_tdata[55:32];
                    ok_next      = s_tdata[56];
                    cmd_next     = '0;
                    fetched_next = bcsc_pkg::FETCH_NONE;
                    valid_next   = 1'b0;
                    value_next   = '0;
                    // temperature queries skip the pressure schedule
                    state_next   = (s_tuser == bcsc_pkg::KIND_TEMP) ? ST_TSCH : ST_PSCH;
                end
            end
            ST_PSCH: begin
                if (press_due) begin
                    press_start_next = '0;
                    press_cache_next = fetch_word;
                    fetched_next     = bcsc_pkg::FETCH_PRESS;
                end else if (press_start_reg == '0 && temp_start_reg == '0) begin
                    cmd_next         = bcsc_pkg::CMD_D1 + {4'd0, ovs_reg};
                    press_start_next = now_reg;
                end
                // no pressure word yet: invalid, temperature schedule skipped
                if ((press_due ? fetch_word : press_cache_reg) == 32'd0) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_TSCH;
                end
            end
            ST_TSCH: begin
                // press_start_reg already reflects this query's pressure step
                if (temp_due) begin
                    temp_start_next = '0;
                    temp_cache_next = fetch_word;
                    fetched_next    = bcsc_pkg::FETCH_TEMP;
                end else if (temp_start_reg == '0 && press_start_reg == '0) begin
                    cmd_next        = bcsc_pkg::CMD_D2 + {4'd0, ovs_reg};
                    temp_start_next = now_reg;
                end
                state_next = ST_DT;
            end
            ST_DT: begin
                dt_next = d32;
                if (temp_cache_reg == 32'd0 || d32 == 32'd0) begin
                    state_next = ST_OUT;
                end else begin
                    valid_next = 1'b1;
                    state_next = (kind_reg == bcsc_pkg::KIND_TEMP) ? ST_MUL_TS : ST_MUL_TCO;
                end
            end
            ST_MUL_TS:  state_next = ST_TFIN;
            ST_TFIN: begin
                value_next = bcsc_pkg::TEMP_BASE + sh_temp;
                state_next = ST_OUT;
            end
            ST_MUL_TCO: state_next = ST_MUL_TCS;
            ST_MUL_TCS: begin
                off_next   = $signed({32'd0, c_off_reg, 16'd0}) + sh_off;
                state_next = ST_SENS;
            end
            ST_SENS: begin
                sens_next  = $signed({33'd0, c_sens_reg, 15'd0}) + sh_sens;
                state_next = ST_PLO;
            end
            ST_PLO:     state_next = ST_PHI;
            ST_PHI: begin
                acc_next   = prod_reg;
                state_next = ST_PSUM;
            end
            ST_PSUM: begin
                acc_next   = acc_reg + $signed({prod_reg[31:0], 32'd0});
                state_next = ST_PFIN;
            end
            ST_PFIN: begin
                value_next = p_val;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // hold until the output register is free, then load it
                if (m_free) begin
                    out_valid_next   = 1'b1;
                    out_cmd_next     = cmd_reg;
                    out_fetched_next = fetched_reg;
                    out_vv_next      = valid_reg;
                    out_value_next   = valid_reg ? value_reg : '0;
                    state_next       = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            c_sens_reg      <= '0;
            c_off_reg       <= '0;
            c_tcs_reg       <= '0;
            c_tco_reg       <= '0;
            c_tref_reg      <= '0;
            c_tsens_reg     <= '0;
            ovs_reg         <= '0;
            wait_reg        <= bcsc_pkg::CONV_WAIT_RESET;
            press_start_reg <= '0;
            temp_start_reg  <= '0;
            press_cache_reg <= '0;
            temp_cache_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            c_sens_reg      <= c_sens_next;
            c_off_reg       <= c_off_next;
            c_tcs_reg       <= c_tcs_next;
            c_tco_reg       <= c_tco_next;
            c_tref_reg      <= c_tref_next;
            c_tsens_reg     <= c_tsens_next;
            ovs_reg         <= ovs_next;
            wait_reg        <= wait_next;
            press_start_reg <= press_start_next;
            temp_start_reg  <= temp_start_next;
            press_cache_reg <= press_cache_next;
            temp_cache_reg  <= temp_cache_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload: no reset needed
    always_ff @(posedge aclk) begin
        kind_reg        <= kind_next;
        now_reg         <= now_next;
        adc_reg         <= adc_next;
        ok_reg          <= ok_next;
        dt_reg          <= dt_next;
        prod_reg        <= prod_next;
        off_reg         <= off_next;
        sens_reg        <= sens_next;
        acc_reg         <= acc_next;
        cmd_reg         <= cmd_next;
        fetched_reg     <= fetched_next;
        valid_reg       <= valid_next;
        value_reg       <= value_next;
        out_cmd_reg     <= out_cmd_next;
        out_fetched_reg <= out_fetched_next;
        out_vv_reg      <= out_vv_next;
        out_value_reg   <= out_value_next;
    end

    // ------------------------------------------------------------------
    // ports
    // ------------------------------------------------------------------
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tuser   = out_vv_reg;
    assign m_tdata   = {6'd0, out_value_reg, out_fetched_reg, out_cmd_reg};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `BCSC_ASSERT_NOW(a_one_pending, 1'b1, press_start_reg == '0 || temp_start_reg == '0, "both conversions pending")
    `BCSC_ASSERT_NOW(a_invalid_zero, out_valid_reg && !out_vv_reg, out_value_reg == '0, "invalid result carries nonzero value")
    `BCSC_ASSERT_NEXT(a_query_entry, s_tvalid && s_tready, state_reg == ST_PSCH || state_reg == ST_TSCH, "query did not enter a schedule step")
    `BCSC_ASSERT_NEXT(a_out_hold, state_reg == ST_OUT && out_valid_reg && !m_tready, state_reg == ST_OUT, "result left while output register full")

endmodule

`default_nettype wire
